// ===== hdl/binary_trie_key_set_assert.svh =====
// assertion macros for the binary trie key set
// used by the top level only, expects clk and rst_n in scope
`ifndef BINARY_TRIE_KEY_SET_ASSERT_SVH
`define BINARY_TRIE_KEY_SET_ASSERT_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
// shared constants and helpers for the binary trie key set
// no dependencies
`default_nettype none

package bts_pkg;

  localparam int KEY_BITS_DEF   = 32;
  localparam int NODE_COUNT_DEF = 4096;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int FREE_W = 12;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;

  // node flags: zero child, one child, key ends here
  localparam int META_W = 3;
  localparam logic [META_W-1:0] META_LEAF = 3'b100;

  function automatic logic [META_W-1:0] child_mask(input logic b);
    child_mask = b ? 3'b010 : 3'b001;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bts_in_if.sv =====
// command channel of the binary trie key set
// depends on bts_pkg
`default_nettype none

interface bts_in_if
  import bts_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [KEY_W-1:0]  key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

`default_nettype wire

// ===== hdl/bts_out_if.sv =====
// result channel of the binary trie key set
// depends on bts_pkg
`default_nettype none

interface bts_out_if
  import bts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              was_present;
  logic [FREE_W-1:0] free_nodes;

  modport source (output valid, status, was_present, free_nodes, input ready);
  modport sink   (input valid, status, was_present, free_nodes, output ready);
endinterface

`default_nettype wire

// ===== hdl/bts_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module bts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ===== hdl/binary_trie_key_set.sv =====
// Binary trie key set: keeps signed keys in a bit-per-level trie held in node memories.
// After reset a clearing pass initializes the node flags and the free stack; no word is
// taken meanwhile. Each command then walks the trie one level per cycle through the node
// memory read port, followed by a decide step. A search ends there. An insert then adds
// the missing nodes one level at a time and finally marks the key end. A delete prunes
// bottom-up through S_DPATH, S_DMETA and S_DUPD for each visited level, since the path
// memory and the node flag memory are read one after the other.
// The result word is held until taken; the next command is accepted after that.
// depends on bts_pkg, bts_in_if, bts_out_if, bts_ram, binary_trie_key_set_assert.svh
`default_nettype none
`include "binary_trie_key_set_assert.svh"

module binary_trie_key_set
  import bts_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  bts_in_if.sink   in_ch,
  bts_out_if.source out_ch
);
  localparam int NW  = $clog2(NODE_COUNT);
  localparam int DW  = $clog2(KEY_BITS + 1);
  localparam int KIW = $clog2(KEY_BITS);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_INS    = 4'd4;
  localparam logic [3:0] S_DPATH  = 4'd5;
  localparam logic [3:0] S_DMETA  = 4'd6;
  localparam logic [3:0] S_DUPD   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [NW-1:0]       fc_r, fc_nxt;
  logic [NW-1:0]       init_r, init_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       last_r, last_nxt;
  logic [META_W-1:0]   lmeta_r, lmeta_nxt;
  logic                first_r, first_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic                was_r, was_nxt;

  logic                meta_we, cz_we, co_we, fs_we, ps_we;
  logic [NW-1:0]       meta_waddr, ch_waddr, fs_waddr, fs_wdata, ch_wdata;
  logic [META_W-1:0]   meta_wdata, meta_q;
  logic [NW-1:0]       node_raddr, fs_raddr, cz_q, co_q, fs_q, ps_wdata, ps_q;
  logic [DW-1:0]       ps_waddr, ps_raddr;

  logic [KIW-1:0]      bidx_cur, bidx_prev;
  logic                b_cur, b_prev, present;
  logic [NW-1:0]       child;
  logic [META_W-1:0]   nm;
  logic [31:0]         need;

  bts_ram #(.WIDTH(META_W), .DEPTH(NODE_COUNT)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(node_raddr), .rdata(meta_q));
  bts_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_czero (
    .clk, .we(cz_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(node_raddr), .rdata(cz_q));
  bts_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_cone (
    .clk, .we(co_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(node_raddr), .rdata(co_q));
  bts_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free (
    .clk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_q));
  bts_ram #(.WIDTH(NW), .DEPTH(KEY_BITS + 1)) u_path (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_q));

  // key bit for level d and for level d-1
  assign bidx_cur  = KIW'(KEY_BITS - 1) - d_r[KIW-1:0];
  assign bidx_prev = bidx_cur + KIW'(1);
  assign b_cur     = (32'(bidx_cur) < KEY_BITS) ? key_r[bidx_cur] : 1'b0;
  assign b_prev    = (32'(bidx_prev) < KEY_BITS) ? key_r[bidx_prev] : 1'b0;
  assign child     = b_cur ? co_q : cz_q;
  assign present   = (d_r == DW'(KEY_BITS)) && lmeta_r[2];
  assign need      = 32'(KEY_BITS) - 32'(d_r);
  assign nm        = meta_q & ~child_mask(b_prev);

  always_comb begin
    state_nxt  = state_r;
    fc_nxt     = fc_r;
    init_nxt   = init_r;
    d_nxt      = d_r;
    n_nxt      = n_r;
    last_nxt   = last_r;
    lmeta_nxt  = lmeta_r;
    first_nxt  = first_r;
    key_nxt    = key_r;
    cmd_nxt    = cmd_r;
    stat_nxt   = stat_r;
    was_nxt    = was_r;
    meta_we    = 1'b0;
    meta_waddr = n_r;
    meta_wdata = '0;
    cz_we      = 1'b0;
    co_we      = 1'b0;
    ch_waddr   = n_r;
    ch_wdata   = fs_q;
    fs_we      = 1'b0;
    fs_waddr   = fc_r;
    fs_wdata   = n_r;
    fs_raddr   = fc_r - NW'(1);
    ps_we      = 1'b0;
    ps_waddr   = d_r + DW'(1);
    ps_wdata   = child;
    ps_raddr   = d_r - DW'(1);
    node_raddr = n_r;
    unique case (state_r)
      S_INIT: begin
        meta_we    = 1'b1;
        meta_waddr = init_r;
        fs_we      = 1'b1;
        fs_waddr   = init_r;
        fs_wdata   = NW'(NODE_COUNT - 1) - init_r;
        init_nxt   = init_r + NW'(1);
        if (init_r == NW'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        node_raddr = '0;
        if (in_ch.valid) begin
          key_nxt   = KEY_BITS'(in_ch.key);
          cmd_nxt   = in_ch.cmd;
          n_nxt     = '0;
          d_nxt     = '0;
          ps_we     = 1'b1;
          ps_waddr  = '0;
          ps_wdata  = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (d_r != DW'(KEY_BITS) && (meta_q & child_mask(b_cur)) != '0) begin
          node_raddr = child;
          ps_we      = 1'b1;
          n_nxt      = child;
          d_nxt      = d_r + DW'(1);
        end else begin
          last_nxt  = n_r;
          lmeta_nxt = meta_q;
          first_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        was_nxt  = present;
        stat_nxt = present ? ST_OK : ST_ABSENT;
        priority if (cmd_r == CMD_INSERT) begin
          if (present) begin
            state_nxt = S_OUT;
          end else if (need > 32'(fc_r)) begin
            stat_nxt  = ST_NOFREE;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_INS;
          end
        end else if (cmd_r == CMD_DELETE && present) begin
          meta_we    = 1'b1;
          meta_waddr = last_r;
          fs_we      = 1'b1;
          fs_wdata   = last_r;
          fc_nxt     = fc_r + NW'(1);
          state_nxt  = S_DPATH;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_INS: begin
        meta_we   = 1'b1;
        first_nxt = 1'b0;
        if (d_r != DW'(KEY_BITS)) begin
          meta_wdata = (first_r ? lmeta_r : '0) | child_mask(b_cur);
          cz_we      = !b_cur;
          co_we      = b_cur;
          fc_nxt     = fc_r - NW'(1);
          fs_raddr   = fc_r - NW'(2);
          n_nxt      = fs_q;
          d_nxt      = d_r + DW'(1);
        end else begin
          meta_wdata = (first_r ? lmeta_r : '0) | META_LEAF;
          stat_nxt   = ST_OK;
          state_nxt  = S_OUT;
        end
      end
      S_DPATH: begin
        state_nxt = S_DMETA;
      end
      S_DMETA: begin
        node_raddr = ps_q;
        n_nxt      = ps_q;
        state_nxt  = S_DUPD;
      end
      S_DUPD: begin
        meta_we = 1'b1;
        if (n_r == '0 || nm != '0) begin
          meta_wdata = nm;
          state_nxt  = S_OUT;
        end else begin
          fs_we     = 1'b1;
          fc_nxt    = fc_r + NW'(1);
          d_nxt     = d_r - DW'(1);
          state_nxt = S_DPATH;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fc_r    <= NW'(NODE_COUNT - 1);
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    last_r  <= last_nxt;
    lmeta_r <= lmeta_nxt;
    first_r <= first_nxt;
    key_r   <= key_nxt;
    cmd_r   <= cmd_nxt;
    stat_r  <= stat_nxt;
    was_r   <= was_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.status      = stat_r;
  assign out_ch.was_present = was_r;
  assign out_ch.free_nodes  = FREE_W'(fc_r);

  `BTS_ASSERT_NOW(a_one_side, in_ch.ready, !out_ch.valid, "ready while a word is pending")
  `BTS_ASSERT_NEXT(a_back_idle, out_ch.valid && out_ch.ready, in_ch.ready,
                   "not ready after result taken")
  `BTS_ASSERT_NOW(a_full_absent, out_ch.valid && out_ch.status == ST_NOFREE, !out_ch.was_present,
                  "no free nodes reported for a present key")
  `BTS_ASSERT_NOW(a_walk_depth, state_r == S_WALK, d_r <= DW'(KEY_BITS), "walk past last level")

endmodule

`default_nettype wire
